### hdl/oor_pkg.sv
// Package for the orbit offset rotator: payload types, pipeline sizes,
// register codes, the arctangent table and the per-stage division helpers.
// No dependencies.
`default_nettype none
package oor_pkg;

    localparam int TICK_BITS     = 48;
    localparam int CORDIC_STAGES = 16;
    localparam int PER_W         = 16;
    localparam int CRD_W         = 34;
    localparam int MOD_STG       = (TICK_BITS + 3) / 4;
    localparam int MOD_PAD       = MOD_STG * 4;
    localparam int DIV_STG       = 8;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = CRD_W'(652032874);

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_PERIOD   = 2'd2;
    localparam logic [1:0] REG_SUSPEND  = 2'd3;

    typedef struct packed {
        logic               sprite_present;
        logic [47:0]        reference_tick;
        logic [47:0]        actual_tick;
        logic [47:0]        extra_tick;
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v3_x;
        logic signed [31:0] v3_y;
    } t_in_item;

    typedef struct packed {
        logic               applied_ok;
        logic signed [31:0] out0_x;
        logic signed [31:0] out0_y;
        logic signed [31:0] out1_x;
        logic signed [31:0] out1_y;
        logic signed [31:0] out2_x;
        logic signed [31:0] out2_y;
        logic signed [31:0] out3_x;
        logic signed [31:0] out3_y;
    } t_out_item;

    typedef struct packed {
        logic             sprite;
        logic [7:0][31:0] v;
    } t_carry;

    typedef struct packed {
        logic [3:0]       q;
        logic [PER_W-1:0] rem;
    } t_divstep;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CRD_W-1:0] atan_turns(input int i);
        case (i)
            0:       return CRD_W'(536870912);
            1:       return CRD_W'(316933406);
            2:       return CRD_W'(167458907);
            3:       return CRD_W'(85004756);
            4:       return CRD_W'(42667331);
            5:       return CRD_W'(21354465);
            6:       return CRD_W'(10679838);
            7:       return CRD_W'(5340245);
            8:       return CRD_W'(2670163);
            9:       return CRD_W'(1335087);
            10:      return CRD_W'(667544);
            11:      return CRD_W'(333772);
            12:      return CRD_W'(166886);
            13:      return CRD_W'(83443);
            14:      return CRD_W'(41722);
            15:      return CRD_W'(20861);
            16:      return CRD_W'(10430);
            17:      return CRD_W'(5215);
            18:      return CRD_W'(2608);
            19:      return CRD_W'(1304);
            20:      return CRD_W'(652);
            21:      return CRD_W'(326);
            22:      return CRD_W'(163);
            23:      return CRD_W'(81);
            default: return '0;
        endcase
    endfunction

    // four restoring steps of a remainder, one dividend bit each
    function automatic logic [PER_W-1:0] mod_step4(input logic [PER_W-1:0] rem,
                                                   input logic [3:0] bits,
                                                   input logic [PER_W-1:0] p);
        logic [PER_W:0]   t;
        logic [PER_W-1:0] r;
        r = rem;
        for (int k = 0; k < 4; k++) begin
            t = {r, bits[3-k]};
            if (t >= {1'b0, p}) begin
                t = t - {1'b0, p};
            end
            r = t[PER_W-1:0];
        end
        return r;
    endfunction

    // four quotient bits of rem * 2^k / p
    function automatic t_divstep div_step4(input logic [PER_W-1:0] rem,
                                           input logic [PER_W-1:0] p);
        logic [PER_W:0] t;
        t_divstep       res;
        res.rem = rem;
        res.q   = '0;
        for (int k = 0; k < 4; k++) begin
            t = {res.rem, 1'b0};
            if (t >= {1'b0, p}) begin
                t = t - {1'b0, p};
                res.q[3-k] = 1'b1;
            end
            res.rem = t[PER_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/orbit_offset_rotator_unit.sv
// Orbit offset rotator top level: config registers, phase pipeline, rotation
// and vertex offset. Depends on oor_pkg, oor_modpipe and oor_cordic.
//
// A transaction is taken in every cycle in which start is high (busy is never
// raised) and its result appears with o_done, one result per transaction in
// order. The result passes through the remainder pipelines (12 stages, four
// tick bits each), the phase index stage, the 32-bit phase division (8
// stages), the 16-stage CORDIC with its output stage, and the multiply, sum
// and vertex add stages. The receiver cannot stall: each result is present
// for one cycle only.
`default_nettype none
module orbit_offset_rotator_unit
    import oor_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic           o_done,
    output t_out_item      o_result
);

    localparam int DX_POS = MOD_STG + DIV_STG + CORDIC_STAGES + 3;
    localparam int LAT    = DX_POS + 2;

    logic signed [31:0]      r_off_x;
    logic signed [31:0]      r_off_y;
    logic [PER_W-1:0]        r_period;
    logic                    r_susp;
    logic [PER_W-1:0]        w_p;
    logic                    w_acc;

    logic [LAT-1:0]          r_vld;
    t_carry                  w_cy_in;
    t_carry                  r_cy [0:DX_POS];

    logic [PER_W-1:0]        w_rem_r, w_rem_a, w_rem_e;
    logic [PER_W+1:0]        w_sum0, w_sum1, w_sum2;
    logic [PER_W-1:0]        r_idx;
    logic [PER_W-1:0]        r_drem [0:DIV_STG-1];
    logic [31:0]             r_q [0:DIV_STG-1];
    logic signed [CRD_W-1:0] w_cos, w_sin;
    logic signed [65:0]      r_p0, r_p1, r_p2, r_p3;
    logic signed [67:0]      w_sx, w_sy;
    logic [31:0]             r_dx, r_dy;
    logic [31:0]             w_dx, w_dy;
    logic                    w_en;
    t_out_item               r_out;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;
    assign w_p   = (r_period == '0) ? PER_W'(1) : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_period <= PER_W'(1);
            r_susp   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X: r_off_x  <= i_cfg_data;
                REG_OFFSET_Y: r_off_y  <= i_cfg_data;
                REG_PERIOD:   r_period <= i_cfg_data[PER_W-1:0];
                REG_SUSPEND:  r_susp   <= i_cfg_data[0];
                default:      r_susp   <= r_susp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    assign w_cy_in.sprite = i_item.sprite_present;
    assign w_cy_in.v = {i_item.v3_y, i_item.v3_x, i_item.v2_y, i_item.v2_x,
                        i_item.v1_y, i_item.v1_x, i_item.v0_y, i_item.v0_x};

    always_ff @(posedge i_clk) begin
        r_cy[0] <= w_cy_in;
        for (int k = 1; k <= DX_POS; k++) begin
            r_cy[k] <= r_cy[k-1];
        end
    end

    oor_modpipe u_mod_ref (.i_clk(i_clk), .i_tick(i_item.reference_tick),
                           .i_period(w_p), .o_rem(w_rem_r));
    oor_modpipe u_mod_act (.i_clk(i_clk), .i_tick(i_item.actual_tick),
                           .i_period(w_p), .o_rem(w_rem_a));
    oor_modpipe u_mod_ext (.i_clk(i_clk), .i_tick(i_item.extra_tick),
                           .i_period(w_p), .o_rem(w_rem_e));

    // sum stays below three periods
    always_comb begin
        w_sum0 = (PER_W+2)'(w_rem_a) + (PER_W+2)'(w_rem_e) + (PER_W+2)'(w_p - w_rem_r);
        w_sum1 = (w_sum0 >= (PER_W+2)'(w_p)) ? w_sum0 - (PER_W+2)'(w_p) : w_sum0;
        w_sum2 = (w_sum1 >= (PER_W+2)'(w_p)) ? w_sum1 - (PER_W+2)'(w_p) : w_sum1;
    end

    always_ff @(posedge i_clk) begin
        r_idx <= w_sum2[PER_W-1:0];
    end

    for (genvar s = 0; s < DIV_STG; s++) begin : g_div
        t_divstep w_st;
        if (s == 0) begin : g_first
            assign w_st = div_step4(r_idx, w_p);
            always_ff @(posedge i_clk) begin
                r_q[s]    <= {w_st.q, 28'd0};
                r_drem[s] <= w_st.rem;
            end
        end else begin : g_next
            assign w_st = div_step4(r_drem[s-1], w_p);
            always_ff @(posedge i_clk) begin
                r_q[s]    <= r_q[s-1] | (32'(w_st.q) << (28 - 4 * s));
                r_drem[s] <= w_st.rem;
            end
        end
    end

    oor_cordic u_cordic (
        .i_clk  (i_clk),
        .i_phase(r_q[DIV_STG-1]),
        .o_cos  (w_cos),
        .o_sin  (w_sin)
    );

    always_ff @(posedge i_clk) begin
        r_p0 <= r_off_x * w_cos;
        r_p1 <= r_off_y * w_sin;
        r_p2 <= r_off_y * w_cos;
        r_p3 <= r_off_x * w_sin;
    end

    assign w_sx = 68'(r_p0) - 68'(r_p1) + 68'sh2000_0000;
    assign w_sy = 68'(r_p2) + 68'(r_p3) + 68'sh2000_0000;

    always_ff @(posedge i_clk) begin
        r_dx <= w_sx[61:30];
        r_dy <= w_sy[61:30];
    end

    assign w_en = r_cy[DX_POS].sprite && !r_susp;
    assign w_dx = w_en ? r_dx : 32'd0;
    assign w_dy = w_en ? r_dy : 32'd0;

    always_ff @(posedge i_clk) begin
        r_out.applied_ok <= r_cy[DX_POS].sprite;
        r_out.out0_x     <= r_cy[DX_POS].v[0] + w_dx;
        r_out.out0_y     <= r_cy[DX_POS].v[1] + w_dy;
        r_out.out1_x     <= r_cy[DX_POS].v[2] + w_dx;
        r_out.out1_y     <= r_cy[DX_POS].v[3] + w_dy;
        r_out.out2_x     <= r_cy[DX_POS].v[4] + w_dx;
        r_out.out2_y     <= r_cy[DX_POS].v[5] + w_dy;
        r_out.out3_x     <= r_cy[DX_POS].v[6] + w_dx;
        r_out.out3_y     <= r_cy[DX_POS].v[7] + w_dy;
    end

    assign o_done   = r_vld[LAT-1];
    assign o_result = r_out;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[MOD_STG-1] |-> (w_rem_r < w_p) && (w_rem_a < w_p) && (w_rem_e < w_p))
        else $error("tick remainder not below period");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[MOD_STG] |-> (r_idx < w_p))
        else $error("phase index not below period");

    a_trig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[MOD_STG+DIV_STG+CORDIC_STAGES+1] |->
            (w_cos < 34'sh0_8000_0000) && (w_cos > -34'sh0_8000_0000) &&
            (w_sin < 34'sh0_8000_0000) && (w_sin > -34'sh0_8000_0000))
        else $error("cordic output out of range");

endmodule
`default_nettype wire

### hdl/oor_modpipe.sv
// Pipelined remainder of one tick count by the period, four bits a stage.
// Depends on oor_pkg.
`default_nettype none
module oor_modpipe
    import oor_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [47:0]      i_tick,
    input  wire logic [PER_W-1:0] i_period,
    output logic      [PER_W-1:0] o_rem
);

    logic [MOD_PAD-1:0] w_dvd;
    logic [PER_W-1:0]   r_rem [0:MOD_STG-1];
    logic [MOD_PAD-1:0] r_dvd [0:MOD_STG-1];

    assign w_dvd = MOD_PAD'(i_tick[TICK_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= mod_step4('0, w_dvd[MOD_PAD-1 -: 4], i_period);
        r_dvd[0] <= w_dvd;
    end

    for (genvar s = 1; s < MOD_STG; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_rem[s] <= mod_step4(r_rem[s-1], r_dvd[s-1][MOD_PAD-1-4*s -: 4], i_period);
            r_dvd[s] <= r_dvd[s-1];
        end
    end

    assign o_rem = r_rem[MOD_STG-1];

endmodule
`default_nettype wire

### hdl/oor_cordic.sv
// Pipelined CORDIC: cosine and sine in signed Q4.30 of a 32-bit turn fraction,
// one iteration a stage plus an output stage. Depends on oor_pkg.
`default_nettype none
module oor_cordic
    import oor_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [31:0]             i_phase,
    output logic signed [CRD_W-1:0]      o_cos,
    output logic signed [CRD_W-1:0]      o_sin
);

    logic                    w_flip;
    logic [31:0]             w_ph;
    logic signed [CRD_W-1:0] r_x [0:CORDIC_STAGES-1];
    logic signed [CRD_W-1:0] r_y [0:CORDIC_STAGES-1];
    logic signed [CRD_W-1:0] r_z [0:CORDIC_STAGES-1];
    logic                    r_f [0:CORDIC_STAGES-1];
    logic signed [CRD_W-1:0] r_c;
    logic signed [CRD_W-1:0] r_s;

    // second and third quarter: rotate by a half turn, negate at the end
    assign w_flip = i_phase[31] ^ i_phase[30];
    assign w_ph   = w_flip ? (i_phase ^ 32'h8000_0000) : i_phase;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [CRD_W-1:0] x_in, y_in, z_in;
        logic                    f_in;
        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = {{(CRD_W-32){w_ph[31]}}, w_ph};
            assign f_in = w_flip;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign f_in = r_f[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!z_in[CRD_W-1]) begin
                r_x[i] <= x_in - (y_in >>> i);
                r_y[i] <= y_in + (x_in >>> i);
                r_z[i] <= z_in - atan_turns(i);
            end else begin
                r_x[i] <= x_in + (y_in >>> i);
                r_y[i] <= y_in - (x_in >>> i);
                r_z[i] <= z_in + atan_turns(i);
            end
            r_f[i] <= f_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f[CORDIC_STAGES-1]) begin
            r_c <= -r_x[CORDIC_STAGES-1];
            r_s <= -r_y[CORDIC_STAGES-1];
        end else begin
            r_c <= r_x[CORDIC_STAGES-1];
            r_s <= r_y[CORDIC_STAGES-1];
        end
    end

    assign o_cos = r_c;
    assign o_sin = r_s;

endmodule
`default_nettype wire
